// ===== sv/whb_pkg.sv =====
// Package for the weighted hit balancer: opcodes, status codes, FSM state and
// the controller/datapath command and status structs. No dependencies.
`default_nettype none
package whb_pkg;
	localparam int unsigned CntW = 32;
	localparam int unsigned PctW = 7;
	localparam int unsigned IdxW = 6;
	// Sum of up to 64 entries of 32 bits.
	localparam int unsigned SumW = 38;
	// Width of x*100 for a 38-bit x.
	localparam int unsigned ProdW = 45;

	typedef enum logic [1:0] {
		OP_PUSH   = 2'd0,
		OP_HIT    = 2'd1,
		OP_UPDATE = 2'd2,
		OP_NONE   = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FAIL = 2'd1,
		ST_DROP = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_HITRD,
		S_SUM,
		S_SUMCHK,
		S_DIVST,
		S_DIVRUN,
		S_REC,
		S_OUT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;     // latch the accepted input item
		logic push;        // write the pushed entry
		logic hit_rd;      // read the hit target
		logic hit_apply;   // apply the hit result
		logic sum_clr;     // clear the totals and walk index
		logic walk_clr;    // clear the walk index only
		logic sum_step;    // add one entry to the totals
		logic div_start;   // load both divisions for the current entry
		logic div_step;    // one quotient bit per division
		logic rec_write;   // store shares and load the record
		logic idx_next;    // advance the walk index
		logic load_single; // load a single-result record
		status_t st;       // status for the single-result record
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		opcode_t op;
		logic    full;
		logic    idx_bad;
		logic    walk_done;  // walk index reached entry count
		logic    tw_zero;
		logic    div_done;
		logic    walk_last;  // current entry is the final one
		logic    hit_ow;     // hit target is marked overweight
	} stat_t;
endpackage
`default_nettype wire

// ===== sv/whb_datapath.sv =====
// Datapath of the weighted hit balancer: entry tables, counters, the two
// bit-serial dividers and the output record register. Uses whb_pkg.
`default_nettype none
module whb_datapath #(
	parameter int unsigned MAX_ENTRIES = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire whb_pkg::cmd_t    cmd,
	output whb_pkg::stat_t        stat,
	input  wire logic [72:0]      in_data,
	output logic [94:0]           rec_data
);
	import whb_pkg::*;

	localparam int unsigned EW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int unsigned NW = $clog2(MAX_ENTRIES + 1);

	logic [CntW-1:0] weight_mem [MAX_ENTRIES];
	logic [CntW-1:0] hit_mem [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0] ow_q;
	logic [PctW-1:0] hshare_mem [MAX_ENTRIES];
	logic [PctW-1:0] gshare_mem [MAX_ENTRIES];

	logic [NW-1:0] count_q;
	logic [CntW-1:0] processed_q, dropped_q;
	logic [72:0] in_q;
	logic [NW-1:0] walk_q;
	logic [SumW-1:0] tw_q, th_q;
	logic [CntW-1:0] rw_q, rh_q;
	logic hit_ow_q;
	logic [ProdW-1:0] wrem_q, hrem_q;
	logic [PctW-1:0] wquo_q, hquo_q;
	logic [5:0] bit_q;
	logic [94:0] rec_q;

	opcode_t op;
	logic [IdxW-1:0] idx;
	logic [EW-1:0] widx, hidx, cidx;
	logic [PctW-1:0] gp, hp;

	assign op = opcode_t'(in_q[1:0]);
	assign idx = in_q[7:2];
	assign widx = walk_q[EW-1:0];
	assign hidx = idx[EW-1:0];
	assign cidx = count_q[EW-1:0];

	assign stat.op = op;
	assign stat.full = (count_q >= NW'(MAX_ENTRIES));
	assign stat.idx_bad = ({1'b0, idx} >= (IdxW+1)'(count_q));
	assign stat.walk_done = (walk_q >= count_q);
	assign stat.tw_zero = (tw_q == '0);
	assign stat.div_done = (bit_q == '0);
	assign stat.walk_last = (walk_q + NW'(1) == count_q);
	assign stat.hit_ow = hit_ow_q;

	// Shares of the current entry; a zero hit total gives a zero hit share.
	assign gp = wquo_q;
	assign hp = (th_q == '0) ? '0 : hquo_q;

	// One step of a long division: the partial remainder is kept in the high
	// bits of a combined remainder/dividend register. Since x*100 < total*128,
	// seven steps give the whole quotient.
	function automatic logic [ProdW+PctW-1:0] div_w(input logic [ProdW-1:0] r,
			input logic [PctW-1:0] q, input logic [SumW-1:0] d);
		logic [ProdW:0] a;
		logic [SumW:0] top;
		a = {r, 1'b0};
		top = a[ProdW:ProdW-SumW];
		if ({1'b0, top} >= {2'b0, d}) begin
			top = top - {1'b0, d};
			a[ProdW:ProdW-SumW] = top;
			div_w = {a[ProdW-1:0], {q[PctW-2:0], 1'b1}};
		end else begin
			div_w = {a[ProdW-1:0], {q[PctW-2:0], 1'b0}};
		end
	endfunction

	// Tables: one write port, reads at the walk index or hit index.
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			weight_mem[cidx] <= in_q[39:8];
			hit_mem[cidx] <= in_q[71:40];
			hshare_mem[cidx] <= '0;
			gshare_mem[cidx] <= '0;
		end else if (cmd.hit_apply && !hit_ow_q && rh_q != '1) begin
			hit_mem[hidx] <= rh_q + CntW'(1);
		end
		if (cmd.rec_write) begin
			hshare_mem[widx] <= hp;
			gshare_mem[widx] <= gp;
		end
		rw_q <= weight_mem[widx];
		rh_q <= cmd.hit_rd ? hit_mem[hidx] : hit_mem[widx];
		if (cmd.hit_rd)
			hit_ow_q <= ow_q[hidx];
	end

	// Control state and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			processed_q <= '0;
			dropped_q <= '0;
			ow_q <= '0;
		end else begin
			if (cmd.push) begin
				count_q <= count_q + NW'(1);
				ow_q[cidx] <= in_q[72];
			end
			if (cmd.hit_apply) begin
				if (hit_ow_q) begin
					if (dropped_q != '1)
						dropped_q <= dropped_q + CntW'(1);
				end else if (processed_q != '1) begin
					processed_q <= processed_q + CntW'(1);
				end
			end
			if (cmd.rec_write)
				ow_q[widx] <= (hp > gp);
		end
	end

	// Input capture, totals, dividers and the output record.
	always_ff @(posedge clk) begin
		if (cmd.capture)
			in_q <= in_data;
		if (cmd.sum_clr) begin
			tw_q <= '0;
			th_q <= '0;
		end
		if (cmd.sum_step) begin
			tw_q <= tw_q + SumW'(rw_q);
			th_q <= th_q + SumW'(rh_q);
		end
		if (cmd.sum_clr || cmd.walk_clr)
			walk_q <= '0;
		else if (cmd.idx_next)
			walk_q <= walk_q + NW'(1);
		if (cmd.div_start) begin
			wrem_q <= ProdW'(rw_q) * ProdW'(100);
			hrem_q <= ProdW'(rh_q) * ProdW'(100);
			wquo_q <= '0;
			hquo_q <= '0;
			bit_q <= 6'(PctW);
		end
		if (cmd.div_step) begin
			bit_q <= bit_q - 6'd1;
			{wrem_q, wquo_q, hrem_q, hquo_q} <= {div_w(wrem_q, wquo_q, tw_q),
				div_w(hrem_q, hquo_q, th_q)};
		end
		if (cmd.rec_write)
			rec_q <= {!stat.walk_last ? 1'b0 : 1'b1, dropped_q, processed_q,
				7'(count_q), (hp > gp), gp, hp,
				IdxW'(walk_q), ST_OK};
		if (cmd.load_single)
			rec_q <= {1'b1, dropped_q, processed_q, 7'(count_q), 1'b0,
				7'd0, 7'd0, 6'd0, cmd.st};
	end

	assign rec_data = rec_q;
	logic unused;
	assign unused = ^{gshare_mem[0], hshare_mem[0]};
endmodule
`default_nettype wire

// ===== sv/whb_ctrl.sv =====
// Controller state machine of the weighted hit balancer. It sequences the
// datapath and the stream handshakes. Uses whb_pkg.
`default_nettype none
module whb_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	output whb_pkg::cmd_t      cmd,
	input  wire whb_pkg::stat_t stat
);
	import whb_pkg::*;

	state_t state_q, state_d;
	logic more_q, more_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			more_q <= 1'b0;
		end else begin
			state_q <= state_d;
			more_q <= more_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		more_d = more_q;
		cmd = '0;
		cmd.st = ST_OK;
		in_ready = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d = S_HITRD;
				end
			end
			S_HITRD: begin
				more_d = 1'b0;
				case (stat.op)
					OP_PUSH: begin
						if (stat.full) begin
							cmd.load_single = 1'b1;
							cmd.st = ST_FAIL;
						end else begin
							cmd.push = 1'b1;
							state_d = S_DIVST;
						end
						if (stat.full)
							state_d = S_OUT;
					end
					OP_HIT: begin
						if (stat.idx_bad) begin
							cmd.load_single = 1'b1;
							cmd.st = ST_FAIL;
							state_d = S_OUT;
						end else begin
							cmd.hit_rd = 1'b1;
							state_d = S_SUMCHK;
						end
					end
					OP_UPDATE: begin
						cmd.sum_clr = 1'b1;
						state_d = S_SUM;
					end
					default: begin
						cmd.load_single = 1'b1;
						cmd.st = ST_FAIL;
						state_d = S_OUT;
					end
				endcase
			end
			S_SUM: begin
				// Read of the walk entry lands in the next cycle.
				if (more_q)
					cmd.sum_step = 1'b1;
				if (stat.walk_done && more_q) begin
					more_d = 1'b0;
					cmd.walk_clr = 1'b1;
					state_d = S_REC;
				end else if (stat.walk_done && !more_q) begin
					cmd.walk_clr = 1'b1;
					state_d = S_REC;
				end else begin
					cmd.idx_next = 1'b1;
					more_d = 1'b1;
				end
			end
			S_SUMCHK: begin
				// Hit read data is valid now.
				cmd.hit_apply = 1'b1;
				state_d = S_DIVST;
			end
			S_DIVST: begin
				// Single result after push or hit; status follows the hit.
				cmd.load_single = 1'b1;
				cmd.st = (stat.op == OP_HIT && stat.hit_ow) ? ST_DROP : ST_OK;
				state_d = S_OUT;
			end
			S_REC: begin
				// Totals done; wait for the walk entry, then divide.
				if (stat.tw_zero) begin
					cmd.load_single = 1'b1;
					state_d = S_OUT;
				end else if (!more_q) begin
					more_d = 1'b1;
				end else begin
					cmd.div_start = 1'b1;
					state_d = S_DIVRUN;
				end
			end
			S_DIVRUN: begin
				if (stat.div_done) begin
					cmd.rec_write = 1'b1;
					state_d = S_OUT;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			S_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (stat.op == OP_UPDATE && more_q && !stat.walk_last &&
					    !stat.tw_zero) begin
						cmd.idx_next = 1'b1;
						more_d = 1'b0;
						state_d = S_REC;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule
`default_nettype wire

// ===== sv/weighted_hit_balancer.sv =====
// Weighted hit balancer: a table of up to MAX_ENTRIES targets with weights and
// hit counts. Push and hit each give one item. Update walks the table twice:
// a summing pass over the entries, then per entry two bit-serial dividers
// running seven steps side by side, one record per entry; a zero weight total
// gives a single item instead. One item is in work at a time.
// Depends on whb_pkg, whb_ctrl and whb_datapath.
`default_nettype none
module weighted_hit_balancer #(
	parameter int unsigned MAX_ENTRIES = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// opcode[1:0], entry_index[7:2], new_weight[39:8], new_hits[71:40],
	// new_overweight[72], zero fill to 80 bits
	input  wire logic [79:0]  s_tdata,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// status[1:0], record_index[7:2], hit_percent[14:8], goal_percent[21:15],
	// is_overweight[22], entries_held[29:23], processed_total[61:30],
	// dropped_total[93:62], zero fill to 96 bits
	output logic [95:0]       m_tdata,
	output logic              m_tlast
);
	import whb_pkg::*;

	cmd_t cmd;
	stat_t stat;
	logic [94:0] rec;
	logic unused_in;

	whb_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_ready(s_tready),
		.out_valid(m_tvalid), .out_ready(m_tready),
		.cmd(cmd), .stat(stat)
	);

	whb_datapath #(.MAX_ENTRIES(MAX_ENTRIES)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.in_data(s_tdata[72:0]), .rec_data(rec)
	);

	assign m_tdata = {2'b0, rec[93:0]};
	assign m_tlast = rec[94];
	assign unused_in = ^s_tdata[79:73];
endmodule
`default_nettype wire

// ===== sv/whb_checker.sv =====
// Port checker for the weighted hit balancer, bound to the top level.
// Depends on whb_pkg and the top level's ports.
`default_nettype none
module whb_assert (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [95:0] m_tdata,
	input wire logic        m_tlast
);
	import whb_pkg::*;

	// Input is never taken while a result is offered.
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid)) else $error("ready while output valid");
	// An offered result holds until taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output dropped");
	// Status is never the unused code.
	a_stat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[1:0] == ST_OK || m_tdata[1:0] == ST_FAIL ||
		m_tdata[1:0] == ST_DROP)) else $error("bad status");
	// Non-update statuses end the run.
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1:0] != ST_OK |-> m_tlast) else $error("last missing");
endmodule

bind weighted_hit_balancer whb_assert u_whb_checker (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
);
`default_nettype wire

// ===== test/whb_checker.sv =====
// Checker for the weighted hit balancer: watches both stream channels, predicts the
// result items of each accepted input item and compares whole data words and last flags.
// Depends on whb_pkg.
`timescale 1ns / 100ps
module whb_checker #(
	parameter int unsigned MAX_ENTRIES = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [79:0] s_tdata,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [95:0] m_tdata,
	input  wire logic        m_tlast,
	output int               fail_count,
	output int               pending_count
);
	import whb_pkg::*;

	// One expected result item: the 96-bit data word and its last flag.
	typedef struct packed {
		logic [95:0] data;
		logic        lst;
	} record_t;

	record_t expected_records[$];

	// Shadow copy of the table and counters.
	logic [31:0] tbl_weight [MAX_ENTRIES];
	logic [31:0] tbl_hits [MAX_ENTRIES];
	logic        tbl_over [MAX_ENTRIES];
	int unsigned tbl_count;
	logic [31:0] hits_ok;
	logic [31:0] hits_dropped;

	function automatic logic [31:0] sat_up(logic [31:0] v);
		return (v == '1) ? v : v + 32'd1;
	endfunction

	function automatic logic [6:0] percent_of(logic [37:0] part, logic [37:0] total);
		logic [44:0] scaled;
		scaled = {7'd0, part} * 45'd100;
		if (total == '0) return '0;
		return 7'(scaled / {7'd0, total});
	endfunction

	// Appends one expected result item built from the current counters.
	task automatic queue_record(status_t st, logic [5:0] idx, logic [6:0] hp,
			logic [6:0] gp, logic ow, logic lst);
		record_t r;
		r.data = {2'b00, hits_dropped, hits_ok, 7'(tbl_count), ow, gp, hp, idx, st};
		r.lst = lst;
		expected_records.push_back(r);
	endtask

	// Updates the shadow table for one accepted input item and queues its expected results.
	task automatic predict_item(logic [79:0] d);
		opcode_t     op;
		logic [5:0]  idx;
		logic [37:0] sum_w;
		logic [37:0] sum_h;
		logic [6:0]  hp;
		logic [6:0]  gp;
		op = opcode_t'(d[1:0]);
		idx = d[7:2];
		sum_w = '0;
		sum_h = '0;
		case (op)
			OP_PUSH: begin
				if (tbl_count >= MAX_ENTRIES) begin
					queue_record(ST_FAIL, '0, '0, '0, 1'b0, 1'b1);
				end else begin
					tbl_weight[tbl_count] = d[39:8];
					tbl_hits[tbl_count] = d[71:40];
					tbl_over[tbl_count] = d[72];
					tbl_count++;
					queue_record(ST_OK, '0, '0, '0, 1'b0, 1'b1);
				end
			end
			OP_HIT: begin
				if (idx >= tbl_count) begin
					queue_record(ST_FAIL, '0, '0, '0, 1'b0, 1'b1);
				end else if (tbl_over[idx]) begin
					hits_dropped = sat_up(hits_dropped);
					queue_record(ST_DROP, '0, '0, '0, 1'b0, 1'b1);
				end else begin
					tbl_hits[idx] = sat_up(tbl_hits[idx]);
					hits_ok = sat_up(hits_ok);
					queue_record(ST_OK, '0, '0, '0, 1'b0, 1'b1);
				end
			end
			OP_UPDATE: begin
				for (int n = 0; n < tbl_count; n++) begin
					sum_w += 38'(tbl_weight[n]);
					sum_h += 38'(tbl_hits[n]);
				end
				if (sum_w == '0) begin
					queue_record(ST_OK, '0, '0, '0, 1'b0, 1'b1);
				end else begin
					for (int n = 0; n < tbl_count; n++) begin
						hp = percent_of(38'(tbl_hits[n]), sum_h);
						gp = percent_of(38'(tbl_weight[n]), sum_w);
						tbl_over[n] = hp > gp;
						queue_record(ST_OK, 6'(n), hp, gp, hp > gp, n + 1 == tbl_count);
					end
				end
			end
			default: begin
				queue_record(ST_FAIL, '0, '0, '0, 1'b0, 1'b1);
			end
		endcase
	endtask

	// Predict on input acceptance, compare on output acceptance.
	always @(posedge clk or negedge arst_n) begin
		record_t want;
		if (!arst_n) begin
			tbl_count = 0;
			hits_ok = '0;
			hits_dropped = '0;
			fail_count <= 0;
			pending_count <= 0;
			expected_records.delete();
		end else begin
			if (s_tvalid && s_tready) predict_item(s_tdata);
			if (m_tvalid && m_tready) begin
				if (expected_records.size() == 0) begin
					if (fail_count < 10)
						$display("whb_checker: unexpected item data=%h last=%b", m_tdata, m_tlast);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_records.pop_front();
					if (want.data !== m_tdata || want.lst !== m_tlast) begin
						if (fail_count < 10)
							$display("whb_checker: mismatch expected %h/%b actual %h/%b",
								want.data, want.lst, m_tdata, m_tlast);
						fail_count <= fail_count + 1;
					end
				end
			end
			pending_count <= expected_records.size();
		end
	end
endmodule

// ===== test/tb_top.sv =====
// Testbench top for the weighted hit balancer: drives directed and random items,
// applies output back-pressure and gives the verdict. Depends on whb_pkg,
// whb_checker and weighted_hit_balancer.
`timescale 1ns / 100ps
module tb_top;
	import whb_pkg::*;

	localparam int unsigned TableSize = 16;
	localparam int unsigned CycleLimit = 400000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [79:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [95:0] m_tdata;
	logic        m_tlast;
	int          fail_count;
	int          pending_count;
	int          cycle_count = 0;
	bit          quiet_phase = 1'b0;
	bit          hold_off = 1'b0;
	// Model of the number of entries, used to aim hits at real entries.
	int          entries_sent = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	weighted_hit_balancer #(.MAX_ENTRIES(TableSize)) u_top (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata,
		.m_tvalid, .m_tready, .m_tdata, .m_tlast
	);

	whb_checker #(.MAX_ENTRIES(TableSize)) u_checker (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata,
		.m_tvalid, .m_tready, .m_tdata, .m_tlast, .fail_count, .pending_count
	);

	// Watchdog on total run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("tb_top: done, errors");
			$finish;
		end
	end

	// Receiver: random stall bursts, a long hold-off on request, none at the end.
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off) begin
				m_tready <= 1'b0;
				repeat (300) @(posedge clk);
				hold_off = 1'b0;
				m_tready <= 1'b1;
			end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
				gap = $urandom_range(1, 6);
				m_tready <= 1'b0;
				repeat (gap - 1) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Offers one item and waits for its acceptance; may idle first.
	task automatic send_item(opcode_t op, logic [5:0] idx, logic [31:0] w,
			logic [31:0] h, logic ow);
		if (!quiet_phase && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'd0, ow, h, w, idx, op};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (op == OP_PUSH && entries_sent < TableSize) entries_sent++;
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 4))
			0: return '0;
			1: return '1;
			2: return $urandom_range(0, 20);
			default: return $urandom;
		endcase
	endfunction

	initial begin
		int kind;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty-table cases, extremes, saturation, full table.
		send_item(OP_UPDATE, '0, '0, '0, 1'b0);
		send_item(OP_HIT, '0, '0, '0, 1'b0);
		send_item(OP_NONE, 6'h3f, '1, '1, 1'b1);
		send_item(OP_PUSH, 6'h3f, '0, '0, 1'b0);
		send_item(OP_UPDATE, '0, '0, '0, 1'b0);
		send_item(OP_PUSH, '0, '1, '1, 1'b0);
		send_item(OP_HIT, 6'd1, '0, '0, 1'b0);
		send_item(OP_PUSH, '0, 32'd3, 32'd0, 1'b1);
		send_item(OP_HIT, 6'd2, '0, '0, 1'b0);
		send_item(OP_HIT, 6'h3f, '0, '0, 1'b0);
		send_item(OP_UPDATE, '0, '0, '0, 1'b0);
		send_item(OP_PUSH, '0, '1, 32'd5, 1'b0);
		send_item(OP_UPDATE, '0, '0, '0, 1'b0);
		send_item(OP_HIT, '0, '0, '0, 1'b0);
		send_item(OP_HIT, 6'd1, '0, '0, 1'b0);
		while (entries_sent < TableSize)
			send_item(OP_PUSH, '0, $urandom, $urandom, 1'($urandom_range(0, 1)));
		send_item(OP_PUSH, '0, 32'd1, 32'd1, 1'b1);
		send_item(OP_UPDATE, '0, '0, '0, 1'b0);

		// Long receiver hold-off while items keep coming, then a full pause.
		hold_off = 1'b1;
		repeat (8) send_item(OP_HIT, 6'($urandom_range(0, 17)), '0, '0, 1'b0);
		wait_drained();

		// Random part: hits dominate, with pushes, updates and noise.
		for (int i = 0; i < 85; i++) begin
			if (i == 70) quiet_phase = 1'b1;
			kind = $urandom_range(0, 19);
			if (kind < 12)
				send_item(OP_HIT, (kind < 10 && entries_sent > 0) ?
					6'($urandom_range(0, entries_sent - 1)) : 6'($urandom),
					$urandom, $urandom, 1'($urandom_range(0, 1)));
			else if (kind < 16)
				send_item(OP_PUSH, 6'($urandom), rand_word(), rand_word(),
					1'($urandom_range(0, 1)));
			else if (kind < 19)
				send_item(OP_UPDATE, 6'($urandom), $urandom, $urandom,
					1'($urandom_range(0, 1)));
			else
				send_item(OP_NONE, 6'($urandom), $urandom, $urandom,
					1'($urandom_range(0, 1)));
		end
		wait_drained();
		repeat (100) @(posedge clk);

		if (fail_count == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end
endmodule
